// ===== hw/rtl/ordered_deque_list_engine_macros.svh =====
`ifndef ORDERED_DEQUE_LIST_ENGINE_MACROS_SVH
`define ORDERED_DEQUE_LIST_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ODL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odl check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ODL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odl check failed");

`endif

// ===== hw/rtl/odl_pkg.sv =====
package odl_pkg;

  localparam int KIND_W   = 4;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    CMD_INIT       = 4'd0,
    CMD_INSERT     = 4'd1,
    CMD_DELETE     = 4'd2,
    CMD_PUSH_BACK  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_PUSH_FRONT = 4'd5,
    CMD_POP_FRONT  = 4'd6,
    CMD_REVERSE    = 4'd7,
    CMD_DUMP       = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_UNINIT   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } chain_t;

endpackage

// ===== hw/rtl/odl_in_if.sv =====
interface odl_in_if;
  import odl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

// ===== hw/rtl/odl_out_if.sv =====
interface odl_out_if #(
  parameter int CNT_W = 5
);
  import odl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] key_out;
  logic [CNT_W-1:0]        count;
  logic                    last;

  modport source (output valid, output status, output key_out, output count, output last,
                  input ready);
  modport sink (input valid, input status, input key_out, input count, input last,
                output ready);
endinterface

// ===== hw/rtl/odl_cell.sv =====
module odl_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  odl_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                 bound,
  input  logic signed [odl_pkg::KEY_W-1:0] key_left,
  input  logic signed [odl_pkg::KEY_W-1:0] key_right,
  output logic signed [odl_pkg::KEY_W-1:0] key_o,
  input  odl_pkg::chain_t                  chain_i,
  output odl_pkg::chain_t                  chain_o
);
  import odl_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;
  logic                    idx_lt;
  logic                    idx_eq;
  logic                    gt_hit;
  logic                    eq_hit;

  assign idx_lt  = IDX_C < bound;
  assign idx_eq  = IDX_C == bound;
  assign gt_hit  = idx_lt && (key_r > ctrl.key);
  assign eq_hit  = idx_lt && (key_r == ctrl.key);
  assign chain_o = '{gt: chain_i.gt | gt_hit, eq: chain_i.eq | eq_hit};
  assign key_o   = key_r;

  always_comb begin
    key_nxt = key_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (chain_i.gt) begin
          key_nxt = key_left;
        end else if (gt_hit || idx_eq) begin
          key_nxt = ctrl.key;
        end
      end
      OP_DELETE: begin
        if (chain_i.eq || eq_hit) begin
          key_nxt = key_right;
        end
      end
      OP_PUSH_BACK: begin
        if (idx_eq) begin
          key_nxt = ctrl.key;
        end
      end
      OP_PUSH_FRONT: begin
        key_nxt = (IDX == 0) ? ctrl.key : key_left;
      end
      OP_POP_FRONT: begin
        key_nxt = key_right;
      end
      OP_ROTATE: begin
        if (idx_lt) begin
          key_nxt = key_right;
        end else if (idx_eq) begin
          key_nxt = ctrl.key;
        end
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== hw/rtl/ordered_deque_list_engine.sv =====
// Channel | Dir | Transaction
// in_ch   | in  | one command: kind, key
// out_ch  | out | one result: status, key_out, count, last
//
// Insert, delete, push, pop and unknown commands finish without leaving the idle state.
// Reverse holds the input during prefix rotations through the cell chain.
// Dump holds the input until all stored keys are emitted, one rotation of the chain per emitted key.
// A waiting result holds off the next command until out_ch takes it.
// rst_n clears control state only; keys stay unknown until written.
module ordered_deque_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  odl_in_if.sink     in_ch,
  odl_out_if.source  out_ch
);
  import odl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_DUMP, S_REV} state_t;

  state_t                  state_r, state_nxt;
  logic                    init_r, init_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic signed [KEY_W-1:0] key_out_r, key_out_nxt;
  logic [CNT_W-1:0]        cnt_out_r, cnt_out_nxt;
  logic                    last_r, last_nxt;

  cell_ctrl_t              ctrl;
  logic [CNT_W-1:0]        bound;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  chain_t                  chain [CAPACITY+1];

  logic                    out_free;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    load;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = count_r == CNT_W'(CAPACITY);
  assign empty       = count_r == '0;
  assign chain[0]    = '{gt: 1'b0, eq: 1'b0};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    odl_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bound     (bound),
      .key_left  ((g == 0) ? ctrl.key : cell_key[(g == 0) ? 0 : g - 1]),
      .key_right ((g == CAPACITY - 1) ? cell_key[g] :
                  cell_key[(g == CAPACITY - 1) ? g : g + 1]),
      .key_o     (cell_key[g]),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    count_nxt   = count_r;
    step_nxt    = step_r;
    ctrl.op     = OP_HOLD;
    ctrl.key    = in_ch.key;
    bound       = count_r;
    load        = 1'b0;
    status_nxt  = status_r;
    key_out_nxt = key_out_r;
    cnt_out_nxt = cnt_out_r;
    last_nxt    = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load        = 1'b1;
          status_nxt  = ST_OK;
          key_out_nxt = '0;
          last_nxt    = 1'b1;
          if (cmd_t'(in_ch.kind) == CMD_INIT) begin
            init_nxt  = 1'b1;
            count_nxt = '0;
          end else if (!init_r) begin
            status_nxt = ST_UNINIT;
          end else begin
            unique case (cmd_t'(in_ch.kind))
              CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (full) begin
                  status_nxt = ST_FULL;
                end else begin
                  count_nxt = count_r + CNT_W'(1);
                  ctrl.op   = (cmd_t'(in_ch.kind) == CMD_INSERT) ? OP_INSERT :
                              (cmd_t'(in_ch.kind) == CMD_PUSH_BACK) ? OP_PUSH_BACK :
                              OP_PUSH_FRONT;
                end
              end
              CMD_DELETE: begin
                if (empty) begin
                  status_nxt = ST_EMPTY;
                end else if (!chain[CAPACITY].eq) begin
                  status_nxt = ST_NOTFOUND;
                end else begin
                  count_nxt = count_r - CNT_W'(1);
                  ctrl.op   = OP_DELETE;
                end
              end
              CMD_POP_BACK, CMD_POP_FRONT: begin
                if (empty) begin
                  status_nxt = ST_EMPTY;
                end else begin
                  count_nxt = count_r - CNT_W'(1);
                  if (cmd_t'(in_ch.kind) == CMD_POP_FRONT) begin
                    ctrl.op = OP_POP_FRONT;
                  end
                end
              end
              CMD_REVERSE: begin
                if (empty) begin
                  status_nxt = ST_EMPTY;
                end else if (count_r > CNT_W'(1)) begin
                  state_nxt = S_REV;
                  step_nxt  = IDX_W'(count_r - CNT_W'(1));
                end
              end
              CMD_DUMP: begin
                if (empty) begin
                  status_nxt = ST_EMPTY;
                end else begin
                  load      = 1'b0;
                  state_nxt = S_DUMP;
                  step_nxt  = IDX_W'(count_r - CNT_W'(1));
                end
              end
              default: begin
                status_nxt = ST_OK;
              end
            endcase
          end
          cnt_out_nxt = (status_nxt == ST_UNINIT) ? '0 : count_nxt;
        end
      end
      S_REV: begin
        ctrl.op  = OP_ROTATE;
        ctrl.key = cell_key[0];
        bound    = CNT_W'(step_r);
        if (step_r == IDX_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          step_nxt = step_r - IDX_W'(1);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.op     = OP_ROTATE;
          ctrl.key    = cell_key[0];
          bound       = count_r - CNT_W'(1);
          load        = 1'b1;
          status_nxt  = ST_OK;
          key_out_nxt = cell_key[0];
          cnt_out_nxt = count_r;
          last_nxt    = step_r == '0;
          if (step_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 1'b0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r  <= status_nxt;
    key_out_r <= key_out_nxt;
    cnt_out_r <= cnt_out_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = status_r;
  assign out_ch.key_out = key_out_r;
  assign out_ch.count   = cnt_out_r;
  assign out_ch.last    = last_r;

endmodule

// ===== hw/rtl/odl_checker.sv =====
`include "ordered_deque_list_engine_macros.svh"

module odl_checker #(
  parameter int CAPACITY = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [odl_pkg::STATUS_W-1:0]     out_status,
  input logic signed [odl_pkg::KEY_W-1:0] out_key_out,
  input logic [$clog2(CAPACITY+1)-1:0]    out_count,
  input logic                             out_last
);
  import odl_pkg::*;

  `ODL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ODL_ASSERT_NOW(a_uninit_count, out_valid && (out_status == ST_UNINIT), out_count == '0)
  `ODL_ASSERT_NOW(a_count_bound, out_valid, out_count <= CAPACITY)
  `ODL_ASSERT_NOW(a_error_single, out_valid && (out_status != ST_OK),
                  out_last && (out_key_out == '0))

endmodule

bind ordered_deque_list_engine odl_checker #(
  .CAPACITY (CAPACITY)
) u_odl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_key_out (out_ch.key_out),
  .out_count   (out_ch.count),
  .out_last    (out_ch.last)
);
